// ===== rtl/hill_cipher_2x2_mod97_decrypt_defines.svh =====
// Assertion shorthands shared by the RTL. Every check is sampled on the
// rising edge of clock and is switched off while reset is high.
`ifndef HILL_CIPHER_2X2_MOD97_DECRYPT_DEFINES_SVH
`define HILL_CIPHER_2X2_MOD97_DECRYPT_DEFINES_SVH

// Condition holds at every edge.
`define HCD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds at the same edge as the antecedent.
`define HCD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds at the edge after the antecedent.
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hcd_pkg.sv =====
package hcd_pkg;

   localparam int ALPHA_SIZE  = 97;
   localparam int SYM_W       = 7;
   localparam int CODE_W      = 8;
   localparam int PROD_W      = 14;
   localparam int ACC_W       = 16;
   localparam int RECIP_W     = 10;
   localparam int RECIP_SHIFT = 16;
   // floor(2^16 / 97): quotient estimate is at most one short for any 16-bit value
   localparam int RECIP_ALPHA = (1 << RECIP_SHIFT) / ALPHA_SIZE;
   // keeps the determinant sum positive before reduction
   localparam int DET_BIAS    = ALPHA_SIZE * ALPHA_SIZE;

   localparam int CSR_INDEX_W    = 2;
   localparam int KEY_COUNT      = 4;
   localparam int KEYGEN_LATENCY = 5;
   localparam int DEF_MID_DEPTH  = 2;
   localparam int DEF_OUT_DEPTH  = 4;

   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [ACC_W-1:0]  acc_type;

   localparam code_type CODE_SPACE           = 8'd32;
   localparam code_type CODE_NEWLINE         = 8'd10;
   localparam code_type CODE_TAB             = 8'd9;
   localparam code_type CODE_FIRST_PRINTABLE = 8'd33;
   localparam code_type CODE_LAST_PRINTABLE  = 8'd126;

   localparam sym_type SYM_SPACE           = 7'd0;
   localparam sym_type SYM_NEWLINE         = 7'd1;
   localparam sym_type SYM_TAB             = 7'd2;
   localparam sym_type SYM_FIRST_PRINTABLE = 7'd3;

   localparam code_type PRINTABLE_OFFSET =
      CODE_FIRST_PRINTABLE - code_type'(SYM_FIRST_PRINTABLE);

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_CIPHER = 3'd1,
      STATUS_BAD_KEY    = 3'd2,
      STATUS_SINGULAR   = 3'd3,
      STATUS_STOPPED    = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_SYMBOL_0 = 2'd0,
      CSR_KEY_SYMBOL_1 = 2'd1,
      CSR_KEY_SYMBOL_2 = 2'd2,
      CSR_KEY_SYMBOL_3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      code_type cipher_first;
      code_type cipher_second;
   } req_type;

   typedef struct packed {
      code_type   plain_first;
      code_type   plain_second;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      sym_type sym;
   } sym_lookup_type;

   typedef struct packed {
      status_type status;
      sym_type    first;
      sym_type    second;
   } front_item_type;

   typedef struct packed {
      logic       busy;
      status_type status;
      sym_type    m00;
      sym_type    m01;
      sym_type    m10;
      sym_type    m11;
   } key_info_type;

   typedef logic [ALPHA_SIZE-1:0][SYM_W-1:0] inv_table_type;

   function automatic inv_table_type build_inv_table();
      inv_table_type t;
      t = '0;
      for (int v = 1; v < ALPHA_SIZE; v++) begin
         for (int i = 1; i < ALPHA_SIZE; i++) begin
            if ((v * i) % ALPHA_SIZE == 1) begin
               t[v] = SYM_W'(i);
            end
         end
      end
      return t;
   endfunction

   localparam inv_table_type INV_TABLE = build_inv_table();

   // reciprocal multiply, then one correcting subtract
   function automatic sym_type mod_alpha(acc_type x);
      logic [ACC_W+RECIP_W-1:0] prod;
      logic [RECIP_W-1:0]       quot;
      acc_type                  rem;
      prod = (ACC_W+RECIP_W)'(x) * (ACC_W+RECIP_W)'(RECIP_ALPHA);
      quot = prod[ACC_W+RECIP_W-1 -: RECIP_W];
      rem  = x - (ACC_W'(quot) * ACC_W'(ALPHA_SIZE));
      if (rem >= ACC_W'(ALPHA_SIZE)) begin
         rem = rem - ACC_W'(ALPHA_SIZE);
      end
      return rem[SYM_W-1:0];
   endfunction

   function automatic sym_lookup_type to_symbol(code_type code);
      sym_lookup_type r;
      r.valid = 1'b1;
      r.sym   = SYM_SPACE;
      if (code == CODE_SPACE) begin
         r.sym = SYM_SPACE;
      end else if (code == CODE_NEWLINE) begin
         r.sym = SYM_NEWLINE;
      end else if (code == CODE_TAB) begin
         r.sym = SYM_TAB;
      end else if (code >= CODE_FIRST_PRINTABLE && code <= CODE_LAST_PRINTABLE) begin
         r.sym = SYM_W'(code - PRINTABLE_OFFSET);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   function automatic code_type to_code(sym_type sym);
      code_type c;
      if (sym == SYM_SPACE) begin
         c = CODE_SPACE;
      end else if (sym == SYM_NEWLINE) begin
         c = CODE_NEWLINE;
      end else if (sym == SYM_TAB) begin
         c = CODE_TAB;
      end else begin
         c = code_type'(sym) + PRINTABLE_OFFSET;
      end
      return c;
   endfunction

   function automatic sym_type neg_alpha(sym_type sym);
      return (sym == '0) ? '0 : (SYM_W'(ALPHA_SIZE) - sym);
   endfunction

endpackage

// ===== rtl/hill_cipher_2x2_mod97_decrypt.sv =====
// 2x2 Hill cipher decryption over a 97-symbol alphabet (space, newline, tab,
// codes 33 to 126).
// Configuration: write the four key characters through csr_write, csr_index
// and csr_data while no transaction is outstanding. Each write restarts a
// five-stage key derivation (inverse matrix modulo 97); req_full stays high
// after the last write until the derivation is through.
// Input: a transaction is taken at a clock edge with req_push high and
// req_full low; req_data carries one ciphertext character pair.
// Output: rsp_data shows the oldest result while rsp_empty is low; rsp_pop
// takes it. Exactly one result per input transaction, in order.
// A pair passes the middle queue and both pipeline stages into the result
// queue. Throughput: one pair per cycle when not stalled, set by the two-stage
// multiply and reduce pipeline with a result queue of four or more entries.
// Errors (bad key symbol, singular key, bad cipher symbol) give a result with
// zero characters and a nonzero status; the block then answers every further
// transaction with the stopped status until reset.
// Reset: synchronous; clears the key to zero, the stop flag and both queues,
// and holds req_full high while the reset key is derived.
// Stall: when rsp_pop stays low the result queue fills, the back end stops
// draining the middle queue and req_full rises; nothing is dropped.
`include "hill_cipher_2x2_mod97_decrypt_defines.svh"

module hill_cipher_2x2_mod97_decrypt
   import hcd_pkg::*;
#(
   parameter int MID_DEPTH = DEF_MID_DEPTH,
   parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  code_type               csr_data
);

   localparam int MID_W = $bits(front_item_type);
   localparam int OUT_W = $bits(rsp_type);

   key_info_type                   key_info;
   logic                           stopped;
   logic                           mid_push, mid_full, mid_pop, mid_empty;
   front_item_type                 mid_in_item, mid_out_item;
   logic [MID_W-1:0]               mid_out_bits;
   logic                           out_push, out_full;
   rsp_type                        out_item;
   logic [OUT_W-1:0]               out_pop_bits;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

   // Derive the decryption matrix from the key registers
   hcd_keygen u_keygen (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key_info  (key_info)
   );

   // Accept and classify; hold the sticky stop flag
   hcd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .mid_full (mid_full),
      .key_info (key_info),
      .mid_push (mid_push),
      .mid_item (mid_in_item),
      .stopped  (stopped)
   );

   // Decouple classification from the arithmetic
   hcd_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH (MID_W)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (MID_W'(mid_in_item)),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_bits),
      .empty     (mid_empty),
      .count     ()
   );

   assign mid_out_item = front_item_type'(mid_out_bits);

   // Multiply, reduce and map back to character codes
   hcd_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_out_item),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .key_info  (key_info),
      .out_count (out_count),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   // Result queue: parts the receiver from the pipeline
   hcd_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH (OUT_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (OUT_W'(out_item)),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_pop_bits),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_data = rsp_type'(out_pop_bits);

   `HCD_ASSERT_ALWAYS(a_out_no_overflow, !(out_push && out_full), "result queue overrun")
   `HCD_ASSERT_NEXT(a_stop_sticky, stopped, stopped, "stop flag dropped without reset")
   `HCD_ASSERT_IMPLY(a_err_zero_chars, !rsp_empty && rsp_data.status != STATUS_OK, rsp_data.plain_first == '0 && rsp_data.plain_second == '0, "error result carries characters")
   `HCD_ASSERT_IMPLY(a_no_accept_busy, mid_push, !key_info.busy, "transaction taken during key derivation")

endmodule

// ===== rtl/hcd_fifo.sv =====
`include "hill_cipher_2x2_mod97_decrypt_defines.svh"

module hcd_fifo
   import hcd_pkg::*;
#(
   parameter int DEPTH = DEF_MID_DEPTH,
   parameter int WIDTH = $bits(front_item_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HCD_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `HCD_ASSERT_IMPLY(a_no_push_full, push, !full, "queue written while full")
   `HCD_ASSERT_NEXT(a_push_fills, push && !full && !pop, !empty, "queue empty after a write")

endmodule

// ===== rtl/hcd_keygen.sv =====
module hcd_keygen
   import hcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  code_type               csr_data,
   output key_info_type           key_info
);

   localparam int BUSY_W = $clog2(KEYGEN_LATENCY + 1);

   code_type          key_ff [KEY_COUNT];
   code_type          key_in [KEY_COUNT];
   logic [BUSY_W-1:0] busy_ff, busy_in;

   sym_lookup_type    look [KEY_COUNT];

   logic       k1_bad_ff, k1_bad_in;
   sym_type    k1_a_ff, k1_b_ff, k1_c_ff, k1_d_ff;
   prod_type   k1_ad_ff, k1_ad_in, k1_bc_ff, k1_bc_in;

   logic       k2_bad_ff;
   sym_type    k2_a_ff, k2_b_ff, k2_c_ff, k2_d_ff;
   sym_type    k2_det_ff, k2_det_in;

   logic       k3_bad_ff, k3_singular_ff, k3_singular_in;
   sym_type    k3_inv_ff, k3_inv_in;
   sym_type    k3_a_ff, k3_d_ff, k3_nb_ff, k3_nb_in, k3_nc_ff, k3_nc_in;

   status_type k4_status_ff, k4_status_in;
   prod_type   k4_p00_ff, k4_p01_ff, k4_p10_ff, k4_p11_ff;
   prod_type   k4_p00_in, k4_p01_in, k4_p10_in, k4_p11_in;

   status_type k5_status_ff;
   sym_type    k5_m00_ff, k5_m01_ff, k5_m10_ff, k5_m11_ff;
   sym_type    k5_m00_in, k5_m01_in, k5_m10_in, k5_m11_in;

   // Register file and derivation countdown
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_SYMBOL_0: key_in[0] = csr_data;
            CSR_KEY_SYMBOL_1: key_in[1] = csr_data;
            CSR_KEY_SYMBOL_2: key_in[2] = csr_data;
            CSR_KEY_SYMBOL_3: key_in[3] = csr_data;
            default: key_in = key_ff;
         endcase
      end
      if (csr_write) begin
         busy_in = BUSY_W'(KEYGEN_LATENCY);
      end else if (busy_ff != '0) begin
         busy_in = busy_ff - 1'b1;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_ff[i] <= '0;
         end
         busy_ff <= BUSY_W'(KEYGEN_LATENCY);
      end else begin
         key_ff  <= key_in;
         busy_ff <= busy_in;
      end
   end

   // Stage 1: symbols and cross products
   always_comb begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         look[i] = to_symbol(key_ff[i]);
      end
      k1_bad_in = !(look[0].valid && look[1].valid && look[2].valid && look[3].valid);
      k1_ad_in  = PROD_W'(look[0].sym) * PROD_W'(look[3].sym);
      k1_bc_in  = PROD_W'(look[1].sym) * PROD_W'(look[2].sym);
   end

   // Stage 2: determinant
   assign k2_det_in = mod_alpha(ACC_W'(k1_ad_ff) + ACC_W'(DET_BIAS) - ACC_W'(k1_bc_ff));

   // Stage 3: inverse determinant and negated off-diagonal terms
   always_comb begin
      k3_inv_in      = INV_TABLE[k2_det_ff];
      k3_singular_in = (k2_det_ff == '0);
      k3_nb_in       = neg_alpha(k2_b_ff);
      k3_nc_in       = neg_alpha(k2_c_ff);
   end

   // Stage 4: scale the adjugate
   always_comb begin
      if (k3_bad_ff) begin
         k4_status_in = STATUS_BAD_KEY;
      end else if (k3_singular_ff) begin
         k4_status_in = STATUS_SINGULAR;
      end else begin
         k4_status_in = STATUS_OK;
      end
      k4_p00_in = PROD_W'(k3_inv_ff) * PROD_W'(k3_d_ff);
      k4_p01_in = PROD_W'(k3_inv_ff) * PROD_W'(k3_nb_ff);
      k4_p10_in = PROD_W'(k3_inv_ff) * PROD_W'(k3_nc_ff);
      k4_p11_in = PROD_W'(k3_inv_ff) * PROD_W'(k3_a_ff);
   end

   // Stage 5: reduce
   always_comb begin
      k5_m00_in = mod_alpha(ACC_W'(k4_p00_ff));
      k5_m01_in = mod_alpha(ACC_W'(k4_p01_ff));
      k5_m10_in = mod_alpha(ACC_W'(k4_p10_ff));
      k5_m11_in = mod_alpha(ACC_W'(k4_p11_ff));
   end

   always_ff @(posedge clock) begin
      k1_bad_ff      <= k1_bad_in;
      k1_a_ff        <= look[0].sym;
      k1_b_ff        <= look[1].sym;
      k1_c_ff        <= look[2].sym;
      k1_d_ff        <= look[3].sym;
      k1_ad_ff       <= k1_ad_in;
      k1_bc_ff       <= k1_bc_in;

      k2_bad_ff      <= k1_bad_ff;
      k2_a_ff        <= k1_a_ff;
      k2_b_ff        <= k1_b_ff;
      k2_c_ff        <= k1_c_ff;
      k2_d_ff        <= k1_d_ff;
      k2_det_ff      <= k2_det_in;

      k3_bad_ff      <= k2_bad_ff;
      k3_singular_ff <= k3_singular_in;
      k3_inv_ff      <= k3_inv_in;
      k3_a_ff        <= k2_a_ff;
      k3_d_ff        <= k2_d_ff;
      k3_nb_ff       <= k3_nb_in;
      k3_nc_ff       <= k3_nc_in;

      k4_status_ff   <= k4_status_in;
      k4_p00_ff      <= k4_p00_in;
      k4_p01_ff      <= k4_p01_in;
      k4_p10_ff      <= k4_p10_in;
      k4_p11_ff      <= k4_p11_in;

      k5_status_ff   <= k4_status_ff;
      k5_m00_ff      <= k5_m00_in;
      k5_m01_ff      <= k5_m01_in;
      k5_m10_ff      <= k5_m10_in;
      k5_m11_ff      <= k5_m11_in;
   end

   always_comb begin
      key_info.busy   = (busy_ff != '0);
      key_info.status = k5_status_ff;
      key_info.m00    = k5_m00_ff;
      key_info.m01    = k5_m01_ff;
      key_info.m10    = k5_m10_ff;
      key_info.m11    = k5_m11_ff;
   end

endmodule

// ===== rtl/hcd_front.sv =====
module hcd_front
   import hcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   input  req_type        req_data,
   output logic           req_full,
   input  logic           mid_full,
   input  key_info_type   key_info,
   output logic           mid_push,
   output front_item_type mid_item,
   output logic           stopped
);

   sym_lookup_type first, second;
   status_type     status;
   logic           stopped_ff, stopped_in;

   assign req_full = mid_full || key_info.busy;
   assign mid_push = req_push && !req_full;
   assign stopped  = stopped_ff;

   // Check order: earlier stop, key symbols, determinant, cipher symbols
   always_comb begin
      first  = to_symbol(req_data.cipher_first);
      second = to_symbol(req_data.cipher_second);
      if (stopped_ff) begin
         status = STATUS_STOPPED;
      end else if (key_info.status != STATUS_OK) begin
         status = key_info.status;
      end else if (!first.valid || !second.valid) begin
         status = STATUS_BAD_CIPHER;
      end else begin
         status = STATUS_OK;
      end
      mid_item.status = status;
      mid_item.first  = first.sym;
      mid_item.second = second.sym;
      stopped_in      = stopped_ff || (mid_push && status != STATUS_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff <= 1'b0;
      end else begin
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== rtl/hcd_back.sv =====
module hcd_back
   import hcd_pkg::*;
#(
   parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  front_item_type                   mid_item,
   input  logic                             mid_empty,
   output logic                             mid_pop,
   input  key_info_type                     key_info,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
   output logic                             out_push,
   output rsp_type                          out_item
);

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic [CNT_W:0] committed;

   logic       b1_valid_ff, b2_valid_ff;
   status_type b1_status_ff;
   prod_type   b1_p00_ff, b1_p01_ff, b1_p10_ff, b1_p11_ff;
   prod_type   b1_p00_in, b1_p01_in, b1_p10_in, b1_p11_in;
   sym_type    s0, s1;
   rsp_type    b2_item_ff, b2_item_in;

   // Take a transaction only when the result queue has room for it and all in flight
   always_comb begin
      committed = (CNT_W+1)'(out_count) + (CNT_W+1)'(b1_valid_ff) + (CNT_W+1)'(b2_valid_ff);
      mid_pop   = !mid_empty && (committed < (CNT_W+1)'(OUT_DEPTH));
   end

   // Stage 1: matrix products
   always_comb begin
      b1_p00_in = PROD_W'(key_info.m00) * PROD_W'(mid_item.first);
      b1_p01_in = PROD_W'(key_info.m01) * PROD_W'(mid_item.second);
      b1_p10_in = PROD_W'(key_info.m10) * PROD_W'(mid_item.first);
      b1_p11_in = PROD_W'(key_info.m11) * PROD_W'(mid_item.second);
   end

   // Stage 2: row sums, reduce, map back to codes
   always_comb begin
      s0 = mod_alpha(ACC_W'(b1_p00_ff) + ACC_W'(b1_p01_ff));
      s1 = mod_alpha(ACC_W'(b1_p10_ff) + ACC_W'(b1_p11_ff));
      b2_item_in.status = b1_status_ff;
      if (b1_status_ff == STATUS_OK) begin
         b2_item_in.plain_first  = to_code(s0);
         b2_item_in.plain_second = to_code(s1);
      end else begin
         b2_item_in.plain_first  = '0;
         b2_item_in.plain_second = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= mid_pop;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_status_ff <= mid_item.status;
      b1_p00_ff    <= b1_p00_in;
      b1_p01_ff    <= b1_p01_in;
      b1_p10_ff    <= b1_p10_in;
      b1_p11_ff    <= b1_p11_in;
      b2_item_ff   <= b2_item_in;
   end

   assign out_push = b2_valid_ff;
   assign out_item = b2_item_ff;

endmodule

// ===== dv/hill_cipher_2x2_mod97_decrypt_tb.sv =====
`timescale 1ns / 1ps

module hill_cipher_2x2_mod97_decrypt_tb;
   import hcd_pkg::*;

   // How the run ends: which of the three first errors stops the block.
   localparam int END_BAD_KEY    = 0;
   localparam int END_SINGULAR   = 1;
   localparam int END_BAD_CIPHER = 2;

   localparam int PHASE_COUNT = 9;
   localparam int PHASE_ITEMS = 150;
   localparam int HOLD_AFTER  = 400;   // transactions accepted before the long hold-off
   localparam int HOLD_CYCLES = 300;

   typedef logic [3:0][7:0] key_word_type;   // [0] row 0 col 0 ... [3] row 1 col 1

   // One row of the directed table: optional key load, a cipher pair, and a
   // hand-written expectation where the answer is obvious.
   typedef struct packed {
      logic         load;
      key_word_type key;
      req_type      req;
      logic         typed;
      rsp_type      want;
   } vector_type;

   logic          clock;
   logic          reset;
   logic          req_push;
   logic          req_full;
   req_type       req_data;
   logic          rsp_empty;
   logic          rsp_pop;
   rsp_type       rsp_data;
   logic          csr_write;
   csr_index_type csr_index;
   code_type      csr_data;

   // Shadow of the block: key registers and the sticky stop flag.
   key_word_type  key_copy = '0;
   bit            halted   = 1'b0;

   rsp_type       pending_plain[$];
   vector_type    vectors[$];
   int            bad_results = 0;
   int            accepted    = 0;
   bit            calm        = 1'b0;
   bit            hold_done   = 1'b0;

   hill_cipher_2x2_mod97_decrypt dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Character code to alphabet index; -1 for a code outside the alphabet.
   function automatic int sym_of(code_type code);
      if (code == CODE_SPACE) return 0;
      if (code == CODE_NEWLINE) return 1;
      if (code == CODE_TAB) return 2;
      if (code >= CODE_FIRST_PRINTABLE && code <= CODE_LAST_PRINTABLE) return int'(code) - 30;
      return -1;
   endfunction

   function automatic code_type char_of(int s);
      if (s == 0) return CODE_SPACE;
      if (s == 1) return CODE_NEWLINE;
      if (s == 2) return CODE_TAB;
      return code_type'(s + 30);
   endfunction

   function automatic int recip97(int v);
      for (int i = 1; i < ALPHA_SIZE; i++) begin
         if ((v * i) % ALPHA_SIZE == 1) return i;
      end
      return 0;
   endfunction

   // Determinant of the key matrix mod 97, or -1 if any key character is unknown.
   function automatic int key_det(key_word_type k);
      int s[4];
      for (int i = 0; i < 4; i++) begin
         s[i] = sym_of(k[i]);
         if (s[i] < 0) return -1;
      end
      return (s[0] * s[3] + ALPHA_SIZE * ALPHA_SIZE - s[1] * s[2]) % ALPHA_SIZE;
   endfunction

   // Decrypt one pair against the shadow key; latches the stop flag on error.
   function automatic rsp_type decrypt_pair(req_type r);
      rsp_type o;
      int      det;
      int      inv;
      int      s0;
      int      s1;
      int      a;
      int      b;
      int      c;
      int      d;
      o = '0;
      o.status = STATUS_OK;
      if (halted) begin
         o.status = STATUS_STOPPED;
         return o;
      end
      // key characters first, then the determinant, then the cipher pair
      det = key_det(key_copy);
      if (det < 0) begin
         halted = 1'b1;
         o.status = STATUS_BAD_KEY;
         return o;
      end
      if (det == 0) begin
         halted = 1'b1;
         o.status = STATUS_SINGULAR;
         return o;
      end
      s0 = sym_of(r.cipher_first);
      s1 = sym_of(r.cipher_second);
      if (s0 < 0 || s1 < 0) begin
         halted = 1'b1;
         o.status = STATUS_BAD_CIPHER;
         return o;
      end
      inv = recip97(det);
      a = sym_of(key_copy[0]);
      b = sym_of(key_copy[1]);
      c = sym_of(key_copy[2]);
      d = sym_of(key_copy[3]);
      // inverse matrix is inv * [d -b; -c a]
      o.plain_first  = char_of((inv * (d * s0 + (ALPHA_SIZE - b) * s1)) % ALPHA_SIZE);
      o.plain_second = char_of((inv * ((ALPHA_SIZE - c) * s0 + a * s1)) % ALPHA_SIZE);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic key_word_type key4(code_type a, code_type b, code_type c, code_type d);
      return {d, c, b, a};
   endfunction

   function automatic code_type any_char();
      return char_of($urandom_range(0, ALPHA_SIZE - 1));
   endfunction

   function automatic code_type bad_char();
      code_type v;
      do v = code_type'($urandom_range(0, 255)); while (sym_of(v) >= 0);
      return v;
   endfunction

   function automatic key_word_type usable_key();
      key_word_type k;
      do begin
         for (int i = 0; i < 4; i++) k[i] = any_char();
      end while (key_det(k) == 0);
      return k;
   endfunction

   function automatic void add_vector(logic load, key_word_type key, code_type c0,
                                      code_type c1, logic typed, code_type p0,
                                      code_type p1, status_type st);
      vector_type v;
      v.load               = load;
      v.key                = key;
      v.req.cipher_first   = c0;
      v.req.cipher_second  = c1;
      v.typed              = typed;
      v.want.plain_first   = p0;
      v.want.plain_second  = p1;
      v.want.status        = st;
      vectors.push_back(v);
   endfunction

   // Offer one pair, hold it until taken, then log what must come back.
   // Entered and left on a falling edge.
   task automatic send_pair(req_type r, logic typed, rsp_type want);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_plain.push_back(typed ? want : decrypt_pair(r));
      accepted++;
      @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, code_type v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      key_copy[idx] = v;
      @(negedge clock);
   endtask

   // Load a whole key once every transaction in flight has come back.
   task automatic load_key(key_word_type k);
      req_push <= 1'b0;
      while (pending_plain.size() != 0) @(negedge clock);
      write_csr(CSR_KEY_SYMBOL_0, k[0]);
      write_csr(CSR_KEY_SYMBOL_1, k[1]);
      write_csr(CSR_KEY_SYMBOL_2, k[2]);
      write_csr(CSR_KEY_SYMBOL_3, k[3]);
      csr_write <= 1'b0;
   endtask

   function automatic req_type any_pair();
      req_type r;
      r.cipher_first  = any_char();
      r.cipher_second = any_char();
      return r;
   endfunction

   function automatic req_type raw_pair();
      req_type r;
      r.cipher_first  = code_type'($urandom_range(0, 255));
      r.cipher_second = code_type'($urandom_range(0, 255));
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: directed table, random phases, then the run-stopping error
   // ---------------------------------------------------------------------
   initial begin : sender
      key_word_type ident;
      key_word_type neg_ident;
      key_word_type k;
      req_type      r;
      int           mode;
      int           which;
      int           a;
      int           b;
      int           t;

      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_KEY_SYMBOL_0;
      csr_data  = '0;

      // identity: newline on the diagonal, space elsewhere, so plain equals cipher
      ident     = key4(CODE_NEWLINE, CODE_SPACE, CODE_SPACE, CODE_NEWLINE);
      // minus identity: every symbol negated mod 97
      neg_ident = key4(CODE_LAST_PRINTABLE, CODE_SPACE, CODE_SPACE, CODE_LAST_PRINTABLE);

      add_vector(1, ident, CODE_TAB, CODE_TAB, 1, CODE_TAB, CODE_TAB, STATUS_OK);
      add_vector(0, ident, CODE_NEWLINE, CODE_SPACE, 1, CODE_NEWLINE, CODE_SPACE, STATUS_OK);
      add_vector(0, ident, CODE_FIRST_PRINTABLE, CODE_LAST_PRINTABLE, 1,
                 CODE_FIRST_PRINTABLE, CODE_LAST_PRINTABLE, STATUS_OK);
      add_vector(0, ident, CODE_LAST_PRINTABLE, CODE_FIRST_PRINTABLE, 1,
                 CODE_LAST_PRINTABLE, CODE_FIRST_PRINTABLE, STATUS_OK);
      add_vector(0, ident, CODE_SPACE, CODE_NEWLINE, 1, CODE_SPACE, CODE_NEWLINE, STATUS_OK);
      add_vector(1, neg_ident, CODE_SPACE, CODE_SPACE, 1, CODE_SPACE, CODE_SPACE, STATUS_OK);
      add_vector(0, neg_ident, CODE_NEWLINE, CODE_NEWLINE, 1,
                 CODE_LAST_PRINTABLE, CODE_LAST_PRINTABLE, STATUS_OK);
      add_vector(0, neg_ident, CODE_LAST_PRINTABLE, CODE_LAST_PRINTABLE, 1,
                 CODE_NEWLINE, CODE_NEWLINE, STATUS_OK);
      add_vector(0, neg_ident, CODE_FIRST_PRINTABLE, CODE_TAB, 0, '0, '0, STATUS_OK);
      // mixed extreme keys: checked against the predictor
      k = key4(CODE_TAB, CODE_LAST_PRINTABLE, CODE_FIRST_PRINTABLE, CODE_NEWLINE);
      add_vector(1, k, CODE_TAB, CODE_LAST_PRINTABLE, 0, '0, '0, STATUS_OK);
      add_vector(0, k, CODE_LAST_PRINTABLE, CODE_TAB, 0, '0, '0, STATUS_OK);
      add_vector(0, k, CODE_FIRST_PRINTABLE, CODE_SPACE, 0, '0, '0, STATUS_OK);
      k = key4(CODE_LAST_PRINTABLE, CODE_LAST_PRINTABLE, CODE_TAB, CODE_FIRST_PRINTABLE);
      add_vector(1, k, CODE_NEWLINE, CODE_NEWLINE, 0, '0, '0, STATUS_OK);
      add_vector(0, k, CODE_LAST_PRINTABLE, CODE_LAST_PRINTABLE, 0, '0, '0, STATUS_OK);
      add_vector(0, k, CODE_SPACE, CODE_FIRST_PRINTABLE, 0, '0, '0, STATUS_OK);

      // hold reset, then release it on a falling edge
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (vectors[i]) begin
         if (vectors[i].load) load_key(vectors[i].key);
         send_pair(vectors[i].req, vectors[i].typed, vectors[i].want);
      end

      // Random phases, each under a fresh usable key; the last one runs flat out.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         if (phase == 0) begin
            k = key4(CODE_TAB, CODE_LAST_PRINTABLE, CODE_LAST_PRINTABLE, CODE_TAB);
         end else if (phase == 1) begin
            k = key4(CODE_LAST_PRINTABLE, CODE_TAB, CODE_TAB, CODE_LAST_PRINTABLE);
         end else begin
            k = usable_key();
         end
         load_key(k);
         repeat (PHASE_ITEMS) send_pair(any_pair(), 1'b0, '0);
      end

      // Stop the block with one of the three errors; the flag only clears on
      // reset, so this comes last. Bad key and singular key carry a raw pair
      // so that the check order is exercised too.
      mode = $urandom_range(END_BAD_KEY, END_BAD_CIPHER);
      case (mode)
         END_BAD_KEY: begin
            k = usable_key();
            k[$urandom_range(0, 3)] = bad_char();
            load_key(k);
            r = raw_pair();
         end
         END_SINGULAR: begin
            // second row a multiple of the first
            a = $urandom_range(0, ALPHA_SIZE - 1);
            b = $urandom_range(0, ALPHA_SIZE - 1);
            t = $urandom_range(0, ALPHA_SIZE - 1);
            load_key(key4(char_of(a), char_of(b), char_of((t * a) % ALPHA_SIZE),
                          char_of((t * b) % ALPHA_SIZE)));
            r = raw_pair();
         end
         default: begin
            which = $urandom_range(0, 2);
            r = any_pair();
            if (which != 1) r.cipher_first  = bad_char();
            if (which != 0) r.cipher_second = bad_char();
         end
      endcase
      send_pair(r, 1'b0, '0);
      repeat (8) send_pair(raw_pair(), 1'b0, '0);

      // a key written after the stop is taken but must not revive the block
      for (int i = 0; i < 4; i++) k[i] = code_type'($urandom_range(0, 255));
      load_key(k);
      repeat (8) send_pair(raw_pair(), 1'b0, '0);

      req_push <= 1'b0;
      while (pending_plain.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (bad_results == 0) begin
         $display("hill_cipher_2x2_mod97_decrypt test passed");
      end else begin
         $display("hill_cipher_2x2_mod97_decrypt test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off to back the block up
   // ---------------------------------------------------------------------
   initial begin : receiver
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && accepted >= HOLD_AFTER) begin
            // hold off long enough for the result queue to fill and req_full to rise
            hold_done = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: compare each popped transaction with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_plain.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("%0t: result %02h %02h status %0d with nothing outstanding",
                        $realtime, rsp_data.plain_first, rsp_data.plain_second,
                        rsp_data.status);
         end else begin
            want = pending_plain.pop_front();
            if (rsp_data.plain_first !== want.plain_first ||
                rsp_data.plain_second !== want.plain_second ||
                rsp_data.status !== want.status) begin
               bad_results++;
               if (bad_results <= 10)
                  $display("%0t: expected %02h %02h status %0d, got %02h %02h status %0d",
                           $realtime, want.plain_first, want.plain_second, want.status,
                           rsp_data.plain_first, rsp_data.plain_second, rsp_data.status);
            end
         end
      end
   end

   // Drop out if the run hangs.
   initial begin : watchdog
      #2000000;
      $display("hill_cipher_2x2_mod97_decrypt test failed");
      $finish;
   end

endmodule
